// ----- hw/rtl/ssr_pkg.sv -----
// Shared types and constants for the soft starter ramp sequencer.
package ssr_pkg;

  localparam int unsigned CMP_W     = 14;
  localparam int unsigned TICK_W    = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned PROD_W    = CMP_W + CNT_W;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CMP_W-1:0]     COMPARE_OFF       = 14'd9001;
  localparam logic [CMP_W-1:0]     INIT_RESET        = 14'd9000;
  localparam logic [TICK_W-1:0]    TICKS_RESET       = 12'd1000;
  localparam logic [CNT_W-1:0]     BRAKE_DELAY_TICKS = 13'd4;
  localparam logic [CNT_W-1:0]     CNT_MAX           = 13'd8191;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS         = 5'd27;

  localparam logic [1:0] REG_INIT_COMPARE = 2'd0;
  localparam logic [1:0] REG_RAMP_TICKS   = 2'd1;
  localparam logic [1:0] REG_BRAKE_TICKS  = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RAMP   = 2'd1,
    MODE_BYPASS = 2'd2,
    MODE_STOP   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CMP_W-1:0]  init_compare;
    logic [TICK_W-1:0] ramp_ticks;
    logic [TICK_W-1:0] brake_ticks;
  } ssr_cfg_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_start;
    logic load_div;
  } ssr_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic slot_free;
  } ssr_sts_t;

endpackage

// ----- hw/rtl/ssr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ssr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ssr_pkg::PROD_W-1:0] dividend_i,
  input  logic [ssr_pkg::TICK_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [ssr_pkg::PROD_W-1:0] quotient_o
);
  import ssr_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    dvd_q, dvd_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     rem_sh;
  logic [CNT_W-1:0]     dsr;
  logic                 ge;

  assign dsr    = {1'b0, divisor_i};
  assign rem_sh = {rem_q[CNT_W-2:0], dvd_q[PROD_W-1]};
  assign ge     = (rem_sh >= dsr);

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[PROD_W-2:0], ge};
      rem_d = ge ? (rem_sh - dsr) : rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = dvd_q;

endmodule

// ----- hw/rtl/ssr_dp.sv -----
// Datapath: sequencer state, stop timing, ramp product and divide, result register.
module ssr_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssr_pkg::ssr_cfg_t         cfg_i,
  input  ssr_pkg::ssr_cmd_t         cmd_i,
  output ssr_pkg::ssr_sts_t         sts_o,
  input  logic                      start_level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssr_pkg::CMP_W-1:0] pwm_compare_o,
  output logic                      brake_on_o,
  output logic [1:0]                phase_o
);
  import ssr_pkg::*;

  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  elapsed_q, elapsed_d;
  logic [CNT_W-1:0]  stop_cnt_q, stop_cnt_d;
  logic [1:0]        hist_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] quot;
  logic              div_busy;

  logic              out_valid_q, out_valid_d;
  logic [CMP_W-1:0]  pwm_q, pwm_d, pwm_now;
  logic              brake_q, brake_d, brake_now;
  mode_e             phase_q, phase_d;

  logic              start_ok, stop_ok, do_stop, need_div, load_direct;
  logic [CNT_W-1:0]  elapsed_inc, stop_c, stop_inc, brake_lim;
  logic              stop_brk, stop_end;

  assign start_ok = start_level_i && hist_q[1];
  assign stop_ok  = !start_level_i && !hist_q[1];

  assign elapsed_inc = (elapsed_q < CNT_MAX) ? elapsed_q + 1'b1 : elapsed_q;
  assign stop_c      = (mode_q == MODE_STOP) ? stop_cnt_q : '0;
  assign stop_inc    = (stop_c < CNT_MAX) ? stop_c + 1'b1 : stop_c;
  assign brake_lim   = BRAKE_DELAY_TICKS + {1'b0, cfg_i.brake_ticks};
  assign stop_brk    = (stop_c >= BRAKE_DELAY_TICKS) && (stop_c < brake_lim);
  assign stop_end    = (stop_c >= brake_lim);

  always_comb begin
    mode_d     = mode_q;
    elapsed_d  = elapsed_q;
    stop_cnt_d = stop_cnt_q;
    pwm_now    = COMPARE_OFF;
    brake_now  = 1'b0;
    need_div   = 1'b0;
    do_stop    = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (start_ok) begin
          mode_d    = MODE_RAMP;
          elapsed_d = '0;
          pwm_now   = cfg_i.init_compare;
        end
      end
      MODE_RAMP: begin
        if (stop_ok) begin
          do_stop = 1'b1;
        end else begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc < {1'b0, cfg_i.ramp_ticks}) begin
            need_div = 1'b1;
          end else begin
            mode_d  = MODE_BYPASS;
            pwm_now = '0;
          end
        end
      end
      MODE_BYPASS: begin
        pwm_now = '0;
        if (stop_ok) begin
          do_stop = 1'b1;
        end
      end
      default: begin
        do_stop = 1'b1;
      end
    endcase
    if (do_stop) begin
      pwm_now = COMPARE_OFF;
      if (stop_end) begin
        mode_d     = MODE_IDLE;
        stop_cnt_d = '0;
      end else begin
        mode_d     = MODE_STOP;
        stop_cnt_d = stop_inc;
        brake_now  = stop_brk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      elapsed_q  <= '0;
      stop_cnt_q <= '0;
      hist_q     <= '0;
    end else if (cmd_i.accept) begin
      mode_q     <= mode_d;
      elapsed_q  <= elapsed_d;
      stop_cnt_q <= stop_cnt_d;
      hist_q     <= {hist_q[0], start_level_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(cfg_i.init_compare) * PROD_W'(elapsed_q);
    end
  end

  ssr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (cfg_i.ramp_ticks),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // result slot
  assign load_direct = cmd_i.accept && !need_div;

  always_comb begin
    out_valid_d = out_valid_q;
    pwm_d       = pwm_q;
    brake_d     = brake_q;
    phase_d     = phase_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_direct) begin
      out_valid_d = 1'b1;
      pwm_d       = pwm_now;
      brake_d     = brake_now;
      phase_d     = mode_d;
    end else if (cmd_i.load_div) begin
      out_valid_d = 1'b1;
      pwm_d       = cfg_i.init_compare - quot[CMP_W-1:0];
      brake_d     = 1'b0;
      phase_d     = MODE_RAMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pwm_q   <= pwm_d;
    brake_q <= brake_d;
    phase_q <= phase_d;
  end

  assign sts_o.need_div  = need_div;
  assign sts_o.div_done  = !div_busy;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pwm_compare_o = pwm_q;
  assign brake_on_o    = brake_q;
  assign phase_o       = phase_q;

endmodule

// ----- hw/rtl/ssr_ctrl.sv -----
// Controller: sequences accept, multiply, divide and result write-back.
module ssr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssr_pkg::ssr_sts_t sts_i,
  output ssr_pkg::ssr_cmd_t cmd_o
);
  import ssr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_LOAD  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_ready_o      = (state_q == S_IDLE) && sts_i.slot_free;
  assign cmd_o.accept    = in_valid_i && in_ready_o;
  assign cmd_o.mul_en    = (state_q == S_MUL);
  assign cmd_o.div_start = (state_q == S_LOAD);
  assign cmd_o.load_div  = (state_q == S_WRITE) && sts_i.slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && sts_i.need_div) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts_i.slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.need_div |=> state_q == S_MUL)
    else $error("ramp beat did not start multiply");

  a_load_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |=> state_q == S_DIV && !sts_i.div_done)
    else $error("divider not busy after start");

  a_div_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && sts_i.div_done |=> state_q == S_WRITE)
    else $error("divide finished without write-back");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.accept && cmd_o.load_div))
    else $error("accept and divide write-back collide");

endmodule

// ----- hw/rtl/soft_starter_ramp_sequencer_core.sv -----
// Top level: APB register file, controller and datapath of the ramp sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid_i/in_ready_o | start_level_i
//  out     | output    | out_valid_o/out_ready_i | pwm_compare_o, brake_on_o, phase_o
//  cfg     | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// Idle, bypass, stop and ramp-end beats: result registered in the cycle after accept.
// Ramp beats: after accept, the result passes through multiply, divider load, the 27-step
// restoring divide with its done check, and write-back once the result slot is free.
// Reset (rst_ni low, async): sequencer mode idle, counters zero, registers at defaults; phase_o is not reset.
// in_ready_o drops from multiply to write-back of a ramp beat and while the result
// register is full and not taken.
module soft_starter_ramp_sequencer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      start_level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssr_pkg::CMP_W-1:0] pwm_compare_o,
  output logic                      brake_on_o,
  output logic [1:0]                phase_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ssr_pkg::*;

  logic [CMP_W-1:0]  init_q;
  logic [TICK_W-1:0] ramp_q;
  logic [TICK_W-1:0] brake_q;
  logic [1:0]        reg_idx;
  logic              wr_en;
  ssr_cfg_t          cfg;
  ssr_cmd_t          cmd;
  ssr_sts_t          sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= INIT_RESET;
      ramp_q  <= TICKS_RESET;
      brake_q <= TICKS_RESET;
    end else if (wr_en) begin
      if (reg_idx == REG_INIT_COMPARE) begin
        init_q <= pwdata[CMP_W-1:0];
      end
      if (reg_idx == REG_RAMP_TICKS) begin
        ramp_q <= pwdata[TICK_W-1:0];
      end
      if (reg_idx == REG_BRAKE_TICKS) begin
        brake_q <= pwdata[TICK_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INIT_COMPARE: prdata = 32'(init_q);
      REG_RAMP_TICKS:   prdata = 32'(ramp_q);
      REG_BRAKE_TICKS:  prdata = 32'(brake_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg.init_compare = init_q;
  assign cfg.ramp_ticks   = ramp_q;
  assign cfg.brake_ticks  = brake_q;

  ssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_level_i (start_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pwm_compare_o (pwm_compare_o),
    .brake_on_o    (brake_on_o),
    .phase_o       (phase_o)
  );

endmodule
